>>> src/ptbl_pkg.sv
// ----------------------------------------------------------------------------
// ptbl_pkg
// Shared types and constants for the paper tape block loader.
// ----------------------------------------------------------------------------
`default_nettype none

package ptbl_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned CHAR_W      = 6;
   localparam int unsigned WORD_W      = 18;
   localparam int unsigned ADDR_W      = 12;
   localparam int unsigned START_W     = 16;
   localparam int unsigned RSP_TDATA_W = 56;

   localparam logic [CHAR_W-1:0]  OPC_DEPOSIT = 6'o32;
   localparam logic [CHAR_W-1:0]  OPC_JUMP    = 6'o60;
   localparam logic [START_W-1:0] START_RESET = 16'd4;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_EXTRA_DATA  = 3'd1,
      ST_UNTERM_RIM  = 3'd2,
      ST_BAD_HEADER  = 3'd3,
      ST_BANK_NZ     = 3'd4,
      ST_ADDR_OVF    = 3'd5
   } status_type;

   typedef enum logic [8:0] {
      PH_START    = 9'b000000001,
      PH_RIM_DATA = 9'b000000010,
      PH_RIM      = 9'b000000100,
      PH_LOOKING  = 9'b000001000,
      PH_END_DIO  = 9'b000010000,
      PH_END_ALT  = 9'b000100000,
      PH_BIN      = 9'b001000000,
      PH_CHECKSUM = 9'b010000000,
      PH_DONE     = 9'b100000000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] tape_byte;
      logic              end_of_tape;
   } req_item_type;

   typedef struct packed {
      logic               write_enable;
      logic [ADDR_W-1:0]  write_address;
      logic [WORD_W-1:0]  write_data;
      logic               finished;
      logic [START_W-1:0] start_address;
      status_type         status;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> src/ptbl_req_stage.sv
// ----------------------------------------------------------------------------
// ptbl_req_stage
// Input register: holds one tape request until the loader consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbl_req_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] tape_byte
   input  wire logic                   req_tlast,   // end_of_tape
   input  wire logic                   advance,
   output logic                        item_valid,
   output ptbl_pkg::req_item_type      item
);
   import ptbl_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.tape_byte   <= req_tdata;
         item_ff.end_of_tape <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

>>> src/ptbl_loader.sv
// ----------------------------------------------------------------------------
// ptbl_loader
// Word assembly and loader state machine; one request handled per cycle while fire is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbl_loader (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_data,
   input  wire logic                   fire,
   input  wire ptbl_pkg::req_item_type item,
   output logic                        has_result,
   output ptbl_pkg::rsp_item_type      result
);
   import ptbl_pkg::*;

   logic                alt_format_ff;
   phase_type           phase_ff,   phase_in;
   logic [1:0]          cnt_ff,     cnt_in;
   logic [11:0]         partial_ff, partial_in;
   logic [12:0]         cur_ff,     cur_in;
   logic [WORD_W-1:0]   end_ff,     end_in;
   logic [START_W-1:0]  start_ff,   start_in;

   logic [WORD_W-1:0]   word;
   logic [CHAR_W-1:0]   op;
   logic [ADDR_W-1:0]   operand;
   logic [12:0]         cur_inc;
   logic                we;
   logic                fin;
   logic [ADDR_W-1:0]   wr_addr;
   status_type          st;

   assign word    = {partial_ff, item.tape_byte[CHAR_W-1:0]};
   assign op      = word[17:12];
   assign operand = word[11:0];
   assign cur_inc = cur_ff + 13'd1;

   always_comb begin
      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      partial_in = partial_ff;
      cur_in     = cur_ff;
      end_in     = end_ff;
      start_in   = start_ff;
      has_result = 1'b0;
      we         = 1'b0;
      fin        = 1'b0;
      st         = ST_OK;
      wr_addr    = cur_ff[11:0];
      if (phase_ff != PH_DONE) begin
         if (item.end_of_tape) begin
            phase_in   = PH_DONE;
            has_result = 1'b1;
            fin        = 1'b1;
         end else if (item.tape_byte[7]) begin
            if (cnt_ff != 2'd2) begin
               partial_in = {partial_ff[5:0], item.tape_byte[CHAR_W-1:0]};
               cnt_in     = cnt_ff + 2'd1;
            end else begin
               partial_in = '0;
               cnt_in     = '0;
               case (phase_ff)
                  PH_START: begin
                     if (op == OPC_DEPOSIT) begin
                        cur_in   = {1'b0, operand};
                        phase_in = PH_RIM_DATA;
                     end
                  end
                  PH_RIM_DATA: begin
                     phase_in   = PH_RIM;
                     has_result = 1'b1;
                     we         = 1'b1;
                  end
                  PH_RIM: begin
                     if (op == OPC_JUMP) begin
                        start_in = {4'b0, operand};
                        phase_in = PH_LOOKING;
                     end else if (op == OPC_DEPOSIT) begin
                        cur_in   = {1'b0, operand};
                        phase_in = PH_RIM_DATA;
                     end else begin
                        phase_in   = PH_DONE;
                        has_result = 1'b1;
                        fin        = 1'b1;
                        st         = ST_UNTERM_RIM;
                     end
                  end
                  PH_LOOKING: begin
                     if (alt_format_ff) begin
                        if (word[17:16] != 2'b00) begin
                           // start word of the alternate format
                           start_in   = word[15:0];
                           phase_in   = PH_DONE;
                           has_result = 1'b1;
                           fin        = 1'b1;
                        end else if (word[15:12] != 4'd0) begin
                           phase_in   = PH_DONE;
                           has_result = 1'b1;
                           fin        = 1'b1;
                           st         = ST_BANK_NZ;
                        end else begin
                           cur_in   = {1'b0, operand};
                           phase_in = PH_END_ALT;
                        end
                     end else if (op == OPC_DEPOSIT) begin
                        cur_in   = {1'b0, operand};
                        phase_in = PH_END_DIO;
                     end else if (op == OPC_JUMP) begin
                        // final jump is also stored unless out of range
                        start_in   = {4'b0, operand};
                        phase_in   = PH_DONE;
                        has_result = 1'b1;
                        fin        = 1'b1;
                        if (cur_ff[12]) begin
                           st = ST_ADDR_OVF;
                        end else begin
                           we = 1'b1;
                        end
                     end else begin
                        phase_in   = PH_DONE;
                        has_result = 1'b1;
                        fin        = 1'b1;
                        st         = ST_EXTRA_DATA;
                     end
                  end
                  PH_END_DIO: begin
                     if (op != OPC_DEPOSIT) begin
                        phase_in   = PH_DONE;
                        has_result = 1'b1;
                        fin        = 1'b1;
                        st         = ST_BAD_HEADER;
                     end else begin
                        end_in   = {6'b0, operand};
                        phase_in = PH_BIN;
                     end
                  end
                  PH_END_ALT: begin
                     end_in   = word;
                     phase_in = PH_BIN;
                  end
                  PH_BIN: begin
                     if (cur_ff[12]) begin
                        phase_in   = PH_DONE;
                        has_result = 1'b1;
                        fin        = 1'b1;
                        st         = ST_ADDR_OVF;
                     end else begin
                        cur_in     = cur_inc;
                        has_result = 1'b1;
                        we         = 1'b1;
                        if ({5'b0, cur_inc} >= end_ff) begin
                           phase_in = alt_format_ff ? PH_LOOKING : PH_CHECKSUM;
                        end
                     end
                  end
                  PH_CHECKSUM: begin
                     phase_in = PH_LOOKING;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      result.write_enable  = we;
      result.write_address = we  ? wr_addr  : '0;
      result.write_data    = we  ? word     : '0;
      result.finished      = fin;
      result.start_address = fin ? start_in : '0;
      result.status        = fin ? st       : ST_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_format_ff <= 1'b0;
      end else if (csr_valid) begin
         alt_format_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         cnt_ff     <= '0;
         partial_ff <= '0;
         cur_ff     <= '0;
         end_ff     <= '0;
         start_ff   <= START_RESET;
      end else if (fire) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         partial_ff <= partial_in;
         cur_ff     <= cur_in;
         end_ff     <= end_in;
         start_ff   <= start_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("character count out of range");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> !has_result)
      else $error("result produced after load finished");

   a_fin_to_done: assert property (@(posedge clock) disable iff (reset)
      (fire && has_result && result.finished) |=> (phase_ff == PH_DONE))
      else $error("finish did not stop the loader");

   a_fin_write_ok: assert property (@(posedge clock) disable iff (reset)
      (has_result && result.finished && result.write_enable) |-> (result.status == ST_OK))
      else $error("final write carries an error status");

endmodule

`default_nettype wire

>>> src/ptbl_rsp_stage.sv
// ----------------------------------------------------------------------------
// ptbl_rsp_stage
// Result register: holds one load result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ptbl_rsp_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire ptbl_pkg::rsp_item_type item,
   output logic                        free,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [11:0] write_address, [29:12] write_data, [45:30] start_address,
   // [48:46] status, [55:49] zero
   output logic [ptbl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tuser,   // write_enable
   output logic                        rsp_tlast    // finished
);
   import ptbl_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = item_ff.write_enable;
   assign rsp_tlast  = item_ff.finished;
   assign rsp_tdata  = {7'b0, item_ff.status, item_ff.start_address,
                        item_ff.write_data, item_ff.write_address};

endmodule

`default_nettype wire

>>> src/paper_tape_block_loader_core.sv
// ----------------------------------------------------------------------------
// paper_tape_block_loader_core
// Paper tape block loader: tape characters in, memory writes and start out.
// ----------------------------------------------------------------------------
// Accepts one tape character per clock and returns at most one result per
// character. A taken request is held in the input register; the word
// assembly and loader state update then run combinationally into the result
// register. Sustained rate is one request per cycle as long as results are
// taken; a held result stalls the input register. No clearing pass follows
// reset. The user must write the format bit on the csr port only while no
// request is in flight; the block does not enforce this.
`default_nettype none

module paper_tape_block_loader_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] tape_byte
   input  wire logic        req_tlast,   // end_of_tape
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [11:0] write_address, [29:12] write_data, [45:30] start_address,
   // [48:46] status, [55:49] zero
   output logic [ptbl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic             rsp_tuser,   // write_enable
   output logic             rsp_tlast,   // finished
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_data     // alt_block_format
);
   import ptbl_pkg::*;

   logic         rsp_free;
   logic         item_valid;
   logic         fire;
   logic         has_result;
   req_item_type req_item;
   rsp_item_type rsp_item;

   assign csr_ready = 1'b1;
   assign fire      = item_valid && rsp_free;

   ptbl_req_stage u_req (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (rsp_free),
      .item_valid (item_valid),
      .item       (req_item)
   );

   ptbl_loader u_loader (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .fire       (fire),
      .item       (req_item),
      .has_result (has_result),
      .result     (rsp_item)
   );

   ptbl_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (fire && has_result),
      .item       (rsp_item),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

>>> bench/paper_tape_block_loader_core_test.sv
// ----------------------------------------------------------------------------
// paper_tape_block_loader_core_test
// Streams tape characters into the loader, predicts its memory writes and
// final start address and status, and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module paper_tape_block_loader_core_test;

   import ptbl_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 6;
   localparam int BODY_CHARS   = 1850;

   typedef enum int {
      FIN_TAPE, FIN_EXTRA, FIN_UNTERM, FIN_BAD_HDR,
      FIN_BANK, FIN_OVERFLOW, FIN_ALT_START, FIN_JUMP
   } load_end_type;

   typedef enum int {RX_READY, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_pattern_type;

   // tracks the loader state and the results it still owes
   class tape_load_tracker_type;
      bit                 fmt_alt;
      phase_type          load_phase;
      bit [1:0]           chars_held;
      bit [ADDR_W-1:0]    char_accum;
      bit [12:0]          next_addr;
      bit [WORD_W-1:0]    last_addr;
      bit [START_W-1:0]   start_reg;
      rsp_item_type       awaited[$];
      int                 errors;

      function new();
         fmt_alt    = 1'b0;
         load_phase = PH_START;
         chars_held = '0;
         char_accum = '0;
         next_addr  = '0;
         last_addr  = '0;
         start_reg  = START_RESET;
         errors     = 0;
      endfunction

      function void queue_result(bit we, bit [12:0] addr, bit [WORD_W-1:0] data,
                                 bit fin, status_type st);
         rsp_item_type r;
         r.write_enable  = we;
         r.write_address = we ? addr[ADDR_W-1:0] : '0;
         r.write_data    = we ? data : '0;
         r.finished      = fin;
         r.start_address = fin ? start_reg : '0;
         r.status        = fin ? st : ST_OK;
         awaited.push_back(r);
      endfunction

      function void end_load(status_type st);
         load_phase = PH_DONE;
         queue_result(1'b0, '0, '0, 1'b1, st);
      endfunction

      function void note_tape_char(bit [BYTE_W-1:0] ch, bit eot);
         bit [WORD_W-1:0] w;
         bit [CHAR_W-1:0] op;
         bit [ADDR_W-1:0] operand;
         if (load_phase == PH_DONE) return;
         if (eot) begin
            end_load(ST_OK);
            return;
         end
         if (!ch[7]) return;
         if (chars_held < 2) begin
            char_accum = {char_accum[5:0], ch[5:0]};
            chars_held++;
            return;
         end
         w          = {char_accum, ch[5:0]};
         char_accum = '0;
         chars_held = '0;
         op         = w[17:12];
         operand    = w[11:0];
         case (load_phase)
            PH_START: begin
               if (op == OPC_DEPOSIT) begin
                  next_addr  = {1'b0, operand};
                  load_phase = PH_RIM_DATA;
               end
            end
            PH_RIM_DATA: begin
               load_phase = PH_RIM;
               queue_result(1'b1, next_addr, w, 1'b0, ST_OK);
            end
            PH_RIM: begin
               if (op == OPC_JUMP) begin
                  start_reg  = {4'b0, operand};
                  load_phase = PH_LOOKING;
               end else if (op == OPC_DEPOSIT) begin
                  next_addr  = {1'b0, operand};
                  load_phase = PH_RIM_DATA;
               end else begin
                  end_load(ST_UNTERM_RIM);
               end
            end
            PH_LOOKING: begin
               if (fmt_alt) begin
                  if (w[17:16] != 2'b00) begin
                     start_reg = w[15:0];
                     end_load(ST_OK);
                  end else if (w > 18'o7777) begin
                     end_load(ST_BANK_NZ);
                  end else begin
                     next_addr  = w[12:0];
                     load_phase = PH_END_ALT;
                  end
               end else if (op == OPC_DEPOSIT) begin
                  next_addr  = {1'b0, operand};
                  load_phase = PH_END_DIO;
               end else if (op == OPC_JUMP) begin
                  // closing jump is stored at the running address too
                  start_reg  = {4'b0, operand};
                  load_phase = PH_DONE;
                  if (next_addr > 13'o7777)
                     queue_result(1'b0, '0, '0, 1'b1, ST_ADDR_OVF);
                  else
                     queue_result(1'b1, next_addr, w, 1'b1, ST_OK);
               end else begin
                  end_load(ST_EXTRA_DATA);
               end
            end
            PH_END_DIO: begin
               if (op != OPC_DEPOSIT) begin
                  end_load(ST_BAD_HEADER);
               end else begin
                  last_addr  = {6'b0, operand};
                  load_phase = PH_BIN;
               end
            end
            PH_END_ALT: begin
               last_addr  = w;
               load_phase = PH_BIN;
            end
            PH_BIN: begin
               if (next_addr > 13'o7777) begin
                  end_load(ST_ADDR_OVF);
               end else begin
                  queue_result(1'b1, next_addr, w, 1'b0, ST_OK);
                  next_addr = next_addr + 13'd1;
                  if (next_addr >= last_addr)
                     load_phase = fmt_alt ? PH_LOOKING : PH_CHECKSUM;
               end
            end
            PH_CHECKSUM: load_phase = PH_LOOKING;
            default: ;
         endcase
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40)
            $display("error at %0t: %s", $time, what);
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         string bad;
         if (awaited.size() == 0) begin
            report($sformatf("result with nothing awaited: %h", got));
            return;
         end
         want = awaited.pop_front();
         if (got.write_enable  !== want.write_enable)  bad = {bad, " write_enable"};
         if (got.write_address !== want.write_address) bad = {bad, " write_address"};
         if (got.write_data    !== want.write_data)    bad = {bad, " write_data"};
         if (got.finished      !== want.finished)      bad = {bad, " finished"};
         if (got.start_address !== want.start_address) bad = {bad, " start_address"};
         if (got.status        !== want.status)        bad = {bad, " status"};
         if (bad != "")
            report($sformatf("field(s)%s differ: got %h, want %h", bad, got, want));
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic                   csr_data   = 1'b0;

   tape_load_tracker_type sb;
   rsp_item_type          got;
   int                    quiet_cycles = 0;
   int                    burst_left   = 0;
   int                    tape_chars   = 0;
   bit                    gen_alt      = 1'b0;
   rx_pattern_type        rx_kind      = RX_READY;
   int                    rx_left      = 0;
   int                    rx_tick      = 0;

   paper_tape_block_loader_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // receiver: switches between stall patterns every so often
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_kind = rx_pattern_type'($urandom_range(0, 3));
         rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      rx_tick++;
      case (rx_kind)
         RX_READY:    rsp_tready <= 1'b1;
         RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         RX_PERIODIC: rsp_tready <= (rx_tick % 4) != 0;
         default:     rsp_tready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.write_enable  = rsp_tuser;
            got.write_address = rsp_tdata[11:0];
            got.write_data    = rsp_tdata[29:12];
            got.finished      = rsp_tlast;
            got.start_address = rsp_tdata[45:30];
            got.status        = status_type'(rsp_tdata[48:46]);
            sb.check_result(got);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("paper_tape_block_loader_core: mismatch");
            $finish;
         end
      end
   end

   function automatic logic [17:0] rand_data();
      case ($urandom_range(0, 7))
         0:       return 18'o0;
         1:       return 18'o777777;
         default: return 18'($urandom);
      endcase
   endfunction

   function automatic logic [11:0] pick_addr();
      case ($urandom_range(0, 9))
         0:       return 12'o0;
         1:       return 12'o7777;
         2:       return 12'($urandom_range(4088, 4095));
         default: return 12'($urandom);
      endcase
   endfunction

   // neither a deposit nor a jump
   function automatic logic [17:0] stray_word();
      logic [17:0] w;
      do w = 18'($urandom);
      while (w[17:12] == OPC_DEPOSIT || w[17:12] == OPC_JUMP);
      return w;
   endfunction

   task automatic send_byte(input logic [7:0] ch, input logic eot);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 48);
      end
      req_tdata  <= ch;
      req_tlast  <= eot;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tape_char(ch, eot);
      if (ch[7] && !eot) tape_chars++;
      burst_left--;
      @(negedge clock);
   endtask

   // three characters, high bits first, with the odd ignored character before any of them
   task automatic send_word(input logic [17:0] w);
      for (int i = 2; i >= 0; i--) begin
         if ($urandom_range(0, 7) == 0)
            send_byte({1'b0, 7'($urandom_range(0, 127))}, 1'b0);
         send_byte({1'b1, 1'($urandom_range(0, 1)), w[6*i +: 6]}, 1'b0);
      end
   endtask

   task automatic hold_requests();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_format(input bit v);
      hold_requests();
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.fmt_alt = v;
      gen_alt    = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [11:0]  lo_addr;
      logic [17:0]  hi_addr;
      logic [12:0]  addr_walk;
      bit           hdr_alt;
      int           span;
      int           pairs;
      load_end_type fin_kind;

      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      fin_kind = load_end_type'($urandom_range(0, 7));
      set_format(1'($urandom_range(0, 1)));

      // read-in block: skipped noise, address extremes, then random pairs
      send_word(18'o0);
      repeat ($urandom_range(0, 2)) send_word(stray_word());
      send_word({OPC_DEPOSIT, 12'o0});
      send_word(18'o777777);
      send_word({OPC_DEPOSIT, 12'o7777});
      send_word(18'o0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7f, 1'b0);
      pairs = (fin_kind == FIN_UNTERM) ? 300 : $urandom_range(0, 6);
      repeat (pairs) begin
         send_word({OPC_DEPOSIT, pick_addr()});
         send_word(rand_data());
      end

      if (fin_kind == FIN_UNTERM) begin
         send_word(stray_word());
      end else begin
         send_word({OPC_JUMP, 12'($urandom)});

         while (tape_chars < BODY_CHARS) begin
            if ($urandom_range(0, 7) == 0) set_format(!gen_alt);
            lo_addr = pick_addr();
            span    = $urandom_range(0, 8);
            hdr_alt = gen_alt;
            if (hdr_alt) begin
               send_word({6'o0, lo_addr});
               if ($urandom_range(0, 3) == 0)
                  hi_addr = 18'($urandom_range(0, lo_addr));
               else if (lo_addr + span > 4096)
                  hi_addr = 18'd4096;
               else
                  hi_addr = 18'(lo_addr + span);
            end else begin
               send_word({OPC_DEPOSIT, lo_addr});
               // end operand can wrap past the top, giving a reversed range
               hi_addr = {6'o0, 12'(lo_addr + span)};
            end
            // header already begun keeps its format
            if ($urandom_range(0, 11) == 0) set_format(!gen_alt);
            send_word(hdr_alt ? hi_addr : {OPC_DEPOSIT, hi_addr[11:0]});
            addr_walk = {1'b0, lo_addr};
            do begin
               send_word(rand_data());
               addr_walk++;
            end while (addr_walk < hi_addr);
            if (!gen_alt) send_word(rand_data());   // checksum
         end

         case (fin_kind)
            FIN_TAPE: begin
               // partial word is dropped
               repeat ($urandom_range(0, 2))
                  send_byte({1'b1, 7'($urandom_range(0, 127))}, 1'b0);
               send_byte(8'($urandom), 1'b1);
            end
            FIN_EXTRA: begin
               set_format(1'b0);
               send_word(stray_word());
            end
            FIN_BAD_HDR: begin
               set_format(1'b0);
               send_word({OPC_DEPOSIT, pick_addr()});
               send_word(($urandom_range(0, 1) == 0) ? stray_word()
                                                      : {OPC_JUMP, 12'($urandom)});
            end
            FIN_BANK: begin
               set_format(1'b1);
               send_word(18'($urandom_range(18'o10000, 18'o177777)));
            end
            FIN_OVERFLOW: begin
               if ($urandom_range(0, 1) == 0) begin
                  set_format(1'b1);
                  lo_addr = 12'($urandom_range(4088, 4095));
                  send_word({6'o0, lo_addr});
                  send_word(18'($urandom_range(4097, 262143)));
                  repeat (4096 - lo_addr + 1) send_word(rand_data());
               end else begin
                  // block ends at the top address, then the closing jump
                  set_format(1'b0);
                  send_word({OPC_DEPOSIT, 12'o7777});
                  send_word({OPC_DEPOSIT, 12'($urandom)});
                  send_word(rand_data());
                  send_word(rand_data());
                  send_word({OPC_JUMP, 12'($urandom)});
               end
            end
            FIN_ALT_START: begin
               set_format(1'b1);
               send_word({2'($urandom_range(1, 3)), 16'($urandom)});
            end
            default: begin
               set_format(1'b0);
               send_word({OPC_JUMP, 12'($urandom)});
            end
         endcase
      end

      // loader is done: nothing more may come out
      repeat (6) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      send_byte(8'($urandom), 1'b1);
      hold_requests();

      if (sb.errors == 0)
         $display("paper_tape_block_loader_core: match");
      else
         $display("paper_tape_block_loader_core: mismatch");
      $finish;
   end

endmodule

>>> paper_tape_block_loader_core.f
src/ptbl_pkg.sv
src/ptbl_req_stage.sv
src/ptbl_loader.sv
src/ptbl_rsp_stage.sv
src/paper_tape_block_loader_core.sv
bench/paper_tape_block_loader_core_test.sv
